@@ sv/pgp_public_key_body_parser_defines.svh @@
// assertion macros for the key body parser
`ifndef PGP_PUBLIC_KEY_BODY_PARSER_DEFINES_SVH
`define PGP_PUBLIC_KEY_BODY_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define PKPB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
`define PKPB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PKPB_ASSERT(label, prop, msg)
`define PKPB_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ sv/pkpb_pkg.sv @@
package pkpb_pkg;

   typedef enum logic [2:0] {
      PH_VERSION = 3'd0,
      PH_TIME    = 3'd1,
      PH_ALGO    = 3'd2,
      PH_LENGTH  = 3'd3,
      PH_DATA    = 3'd4,
      PH_TRAIL   = 3'd5
   } phase_type;

   localparam logic [2:0] KIND_VERSION = 3'd0;
   localparam logic [2:0] KIND_TIME    = 3'd1;
   localparam logic [2:0] KIND_ALGO    = 3'd2;
   localparam logic [2:0] KIND_LENGTH  = 3'd3;
   localparam logic [2:0] KIND_DATA    = 3'd4;
   localparam logic [2:0] KIND_TRAIL   = 3'd5;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_BAD_VERSION = 2'd1;
   localparam logic [1:0] STATUS_BAD_ALGO    = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED   = 2'd3;

   localparam logic [1:0] CLASS_UNKNOWN = 2'd0;
   localparam logic [1:0] CLASS_RSA     = 2'd1;
   localparam logic [1:0] CLASS_ELGAMAL = 2'd2;
   localparam logic [1:0] CLASS_DSA     = 2'd3;

   localparam logic [7:0] VERSION_CODE      = 8'd4;
   localparam logic [7:0] ALG_RSA_ENC_SIGN  = 8'd1;
   localparam logic [7:0] ALG_RSA_ENC       = 8'd2;
   localparam logic [7:0] ALG_RSA_SIGN      = 8'd3;
   localparam logic [7:0] ALG_ELGAMAL       = 8'd16;
   localparam logic [7:0] ALG_DSA           = 8'd17;

   localparam logic [2:0] MPI_COUNT_NONE    = 3'd0;
   localparam logic [2:0] MPI_COUNT_RSA     = 3'd2;
   localparam logic [2:0] MPI_COUNT_ELGAMAL = 3'd3;
   localparam logic [2:0] MPI_COUNT_DSA     = 3'd4;

   localparam int OffsetWidth = 13;
   localparam int LeftWidth   = 14;
   localparam logic [OffsetWidth-1:0] TIME_LAST_OFFSET = OffsetWidth'(3);

   typedef struct packed {
      phase_type              phase;
      logic [OffsetWidth-1:0] field_offset;
      logic [1:0]             current_mpi;
      logic [2:0]             mpi_total;
      logic [LeftWidth-1:0]   data_bytes_left;
      logic [7:0]             length_high_byte;
      logic [31:0]            time_acc;
      logic [1:0]             sticky_status;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:            PH_VERSION,
      field_offset:     '0,
      current_mpi:      '0,
      mpi_total:        MPI_COUNT_NONE,
      data_bytes_left:  '0,
      length_high_byte: '0,
      time_acc:         '0,
      sticky_status:    STATUS_OK
   };

   typedef struct packed {
      logic [2:0]             field_kind;
      logic [1:0]             mpi_number;
      logic [OffsetWidth-1:0] offset_in_field;
      logic [7:0]             byte_value;
      logic                   field_done;
      logic [1:0]             algorithm_class;
      logic [31:0]            created_time;
      logic [1:0]             status;
   } result_type;

endpackage

@@ sv/pkpb_req_if.sv @@
interface pkpb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       body_end;

   modport source (output valid, output body_byte, output body_end, input ready);
   modport sink (input valid, input body_byte, input body_end, output ready);
endinterface

@@ sv/pkpb_rsp_if.sv @@
interface pkpb_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  field_kind;
   logic [1:0]  mpi_number;
   logic [12:0] offset_in_field;
   logic [7:0]  byte_value;
   logic        field_done;
   logic [1:0]  algorithm_class;
   logic [31:0] created_time;
   logic [1:0]  status;

   modport source (output valid, output field_kind, output mpi_number,
                   output offset_in_field, output byte_value, output field_done,
                   output algorithm_class, output created_time, output status,
                   input ready);
   modport sink (input valid, input field_kind, input mpi_number,
                 input offset_in_field, input byte_value, input field_done,
                 input algorithm_class, input created_time, input status,
                 output ready);
endinterface

@@ sv/pkpb_step.sv @@
module pkpb_step
   import pkpb_pkg::*;
(
   input  state_type  cur_state,
   input  logic [7:0] body_byte,
   input  logic       body_end,
   output state_type  state_in,
   output result_type result
);

   state_type            nxt;
   logic [2:0]           kind;
   logic [1:0]           mpi;
   logic [OffsetWidth-1:0] off;
   logic                 done;
   logic [1:0]           cls;
   logic [16:0]          bits_round;
   logic [LeftWidth-1:0] left_dec;
   logic [2:0]           mpi_plus;

   always_comb begin
      nxt        = cur_state;
      kind       = KIND_TRAIL;
      mpi        = '0;
      off        = '0;
      done       = 1'b0;
      cls        = CLASS_UNKNOWN;
      bits_round = {1'b0, cur_state.length_high_byte, body_byte} + 17'd7;
      left_dec   = (cur_state.data_bytes_left == '0) ? '0
                                                     : cur_state.data_bytes_left - LeftWidth'(1);
      mpi_plus   = {1'b0, cur_state.current_mpi} + 3'd1;

      unique case (cur_state.phase)
         PH_VERSION: begin
            kind = KIND_VERSION;
            done = 1'b1;
            if (body_byte != VERSION_CODE && nxt.sticky_status == STATUS_OK) begin
               nxt.sticky_status = STATUS_BAD_VERSION;
            end
            nxt.phase        = PH_TIME;
            nxt.field_offset = '0;
         end
         PH_TIME: begin
            kind         = KIND_TIME;
            off          = cur_state.field_offset;
            nxt.time_acc = {cur_state.time_acc[23:0], body_byte};
            if (cur_state.field_offset >= TIME_LAST_OFFSET) begin
               done             = 1'b1;
               nxt.field_offset = '0;
               nxt.phase        = PH_ALGO;
            end else begin
               nxt.field_offset = cur_state.field_offset + OffsetWidth'(1);
            end
         end
         PH_ALGO: begin
            kind             = KIND_ALGO;
            done             = 1'b1;
            nxt.field_offset = '0;
            nxt.current_mpi  = '0;
            unique case (body_byte) inside
               ALG_RSA_ENC_SIGN, ALG_RSA_ENC, ALG_RSA_SIGN: nxt.mpi_total = MPI_COUNT_RSA;
               ALG_ELGAMAL: nxt.mpi_total = MPI_COUNT_ELGAMAL;
               ALG_DSA:     nxt.mpi_total = MPI_COUNT_DSA;
               default:     nxt.mpi_total = MPI_COUNT_NONE;
            endcase
            if (nxt.mpi_total == MPI_COUNT_NONE) begin
               if (nxt.sticky_status == STATUS_OK) begin
                  nxt.sticky_status = STATUS_BAD_ALGO;
               end
               nxt.phase = PH_TRAIL;
            end else begin
               nxt.phase = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            kind = KIND_LENGTH;
            mpi  = cur_state.current_mpi;
            off  = cur_state.field_offset;
            if (cur_state.field_offset == '0) begin
               nxt.length_high_byte = body_byte;
               nxt.field_offset     = OffsetWidth'(1);
            end else begin
               // data length is the bit count rounded up to whole bytes
               done                 = 1'b1;
               nxt.data_bytes_left  = bits_round[16:3];
               nxt.field_offset     = '0;
               if (bits_round[16:3] != '0) begin
                  nxt.phase = PH_DATA;
               end else if (mpi_plus < cur_state.mpi_total) begin
                  nxt.current_mpi = mpi_plus[1:0];
                  nxt.phase       = PH_LENGTH;
               end else begin
                  nxt.phase = PH_TRAIL;
               end
            end
         end
         PH_DATA: begin
            kind                = KIND_DATA;
            mpi                 = cur_state.current_mpi;
            off                 = cur_state.field_offset;
            nxt.data_bytes_left = left_dec;
            if (left_dec == '0) begin
               done             = 1'b1;
               nxt.field_offset = '0;
               if (mpi_plus < cur_state.mpi_total) begin
                  nxt.current_mpi = mpi_plus[1:0];
                  nxt.phase       = PH_LENGTH;
               end else begin
                  nxt.phase = PH_TRAIL;
               end
            end else begin
               nxt.field_offset = cur_state.field_offset + OffsetWidth'(1);
            end
         end
         default: begin
            // trailing bytes, offset saturates at all ones
            kind = KIND_TRAIL;
            off  = cur_state.field_offset;
            if (cur_state.field_offset != '1) begin
               nxt.field_offset = cur_state.field_offset + OffsetWidth'(1);
            end
         end
      endcase

      if (body_end && nxt.phase != PH_TRAIL && nxt.sticky_status == STATUS_OK) begin
         nxt.sticky_status = STATUS_TRUNCATED;
      end

      unique case (nxt.mpi_total)
         MPI_COUNT_RSA:     cls = CLASS_RSA;
         MPI_COUNT_ELGAMAL: cls = CLASS_ELGAMAL;
         MPI_COUNT_DSA:     cls = CLASS_DSA;
         default:           cls = CLASS_UNKNOWN;
      endcase

      result.field_kind      = kind;
      result.mpi_number      = mpi;
      result.offset_in_field = off;
      result.byte_value      = body_byte;
      result.field_done      = done;
      result.algorithm_class = cls;
      result.created_time    = nxt.time_acc;
      result.status          = nxt.sticky_status;

      state_in = body_end ? STATE_RESET : nxt;
   end

endmodule

@@ sv/pkpb_out_stage.sv @@
module pkpb_out_stage
   import pkpb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_data,
   output logic       in_ready,
   output logic       out_valid,
   output result_type out_data,
   input  logic       out_ready
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // a new transfer may enter while the held one leaves in the same cycle
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

endmodule

@@ sv/pgp_public_key_body_parser.sv @@
// Key body parser: tags each byte of a version-4 public key packet body.
// req_chan carries body_byte and body_end, one body byte per transfer;
// body_end marks the last byte of a body and the next byte starts a new one.
// rsp_chan returns exactly one result per accepted byte: its field kind,
// integer number, offset in the field, the byte itself, a field-done flag,
// the algorithm class, the creation time gathered so far and the sticky
// status of the body.
// A byte accepted at a clock edge has its result valid after that edge.
// Throughput is one byte per cycle while rsp_chan takes results; the parse state
// update and result build sit in one stage in front of the result register.
// When rsp_chan stalls, the result register holds its transfer and req_chan
// still accepts in the cycle the held result is taken; otherwise req ready
// drops until the result leaves.
// Synchronous reset empties the result register and returns the parser to
// the version byte with cleared time, integer counters and status.
`include "pgp_public_key_body_parser_defines.svh"

module pgp_public_key_body_parser
   import pkpb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   pkpb_req_if.sink   req_chan,
   pkpb_rsp_if.source rsp_chan
);

   state_type  state_ff;
   state_type  state_in;
   result_type step_result;
   result_type rsp_data;
   logic       req_ready;
   logic       req_fire;
   logic       rsp_valid;

   assign req_chan.ready = req_ready;
   assign req_fire       = req_chan.valid && req_ready;

   pkpb_step u_step (
      .cur_state (state_ff),
      .body_byte (req_chan.body_byte),
      .body_end  (req_chan.body_end),
      .state_in  (state_in),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   pkpb_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_data   (step_result),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.field_kind      = rsp_data.field_kind;
   assign rsp_chan.mpi_number      = rsp_data.mpi_number;
   assign rsp_chan.offset_in_field = rsp_data.offset_in_field;
   assign rsp_chan.byte_value      = rsp_data.byte_value;
   assign rsp_chan.field_done      = rsp_data.field_done;
   assign rsp_chan.algorithm_class = rsp_data.algorithm_class;
   assign rsp_chan.created_time    = rsp_data.created_time;
   assign rsp_chan.status          = rsp_data.status;

   `PKPB_ASSERT_ALWAYS(a_reset_to_version, reset |=> state_ff.phase == PH_VERSION, "reset did not return to version")
   `PKPB_ASSERT(a_end_restarts, req_fire && req_chan.body_end |=> state_ff == STATE_RESET, "body end did not restart parser")
   `PKPB_ASSERT(a_fire_gives_result, req_fire |=> rsp_valid, "accepted byte produced no result")
   `PKPB_ASSERT(a_status_sticky, state_ff.sticky_status != STATUS_OK && !(req_fire && req_chan.body_end) |=> state_ff.sticky_status == $past(state_ff.sticky_status), "sticky status changed inside a body")
   `PKPB_ASSERT(a_data_left_nonzero, state_ff.phase == PH_DATA |-> state_ff.data_bytes_left != '0, "data phase with no bytes left")
   `PKPB_ASSERT(a_trail_not_done, rsp_valid && rsp_data.field_kind == KIND_TRAIL |-> !rsp_data.field_done, "trailing byte flagged as field done")

endmodule

@@ bench/pgp_public_key_body_parser_tb.sv @@
`timescale 1ns / 1ps

module pgp_public_key_body_parser_tb;
   import pkpb_pkg::*;

   localparam logic [13:0] TRAIL_OFFSET_MAX = 14'd8191;

   class byte_tag_checker;
      phase_type   phase;
      logic [13:0] offset;
      logic [1:0]  mpi_index;
      logic [2:0]  mpi_count;
      logic [13:0] bytes_left;
      logic [7:0]  length_high;
      logic [31:0] time_acc;
      logic [1:0]  sticky;
      result_type  expected_tags[$];
      int          mismatches;

      function new();
         mismatches = 0;
         clear_state();
      endfunction

      function void clear_state();
         phase = PH_VERSION;
         offset = '0;
         mpi_index = '0;
         mpi_count = MPI_COUNT_NONE;
         bytes_left = '0;
         length_high = '0;
         time_acc = '0;
         sticky = STATUS_OK;
      endfunction

      function void raise_status(logic [1:0] code);
         if (sticky == STATUS_OK) sticky = code;
      endfunction

      function void advance_integer();
         offset = '0;
         if (int'(mpi_index) + 1 < int'(mpi_count)) begin
            mpi_index = mpi_index + 2'd1;
            phase = PH_LENGTH;
         end else begin
            phase = PH_TRAIL;
         end
      endfunction

      function int pending();
         return expected_tags.size();
      endfunction

      // one accepted body byte gives exactly one tagged byte
      function void note_body_byte(logic [7:0] b, logic last);
         result_type tag;
         logic [16:0] bits;
         tag = '0;
         tag.field_kind = KIND_TRAIL;
         tag.byte_value = b;
         case (phase)
            PH_VERSION: begin
               tag.field_kind = KIND_VERSION;
               tag.field_done = 1'b1;
               if (b != VERSION_CODE) raise_status(STATUS_BAD_VERSION);
               phase = PH_TIME;
               offset = '0;
            end
            PH_TIME: begin
               tag.field_kind = KIND_TIME;
               tag.offset_in_field = offset[12:0];
               time_acc = {time_acc[23:0], b};
               if (offset >= 14'd3) begin
                  tag.field_done = 1'b1;
                  offset = '0;
                  phase = PH_ALGO;
               end else begin
                  offset = offset + 14'd1;
               end
            end
            PH_ALGO: begin
               tag.field_kind = KIND_ALGO;
               tag.field_done = 1'b1;
               offset = '0;
               mpi_index = '0;
               if (b >= ALG_RSA_ENC_SIGN && b <= ALG_RSA_SIGN) mpi_count = MPI_COUNT_RSA;
               else if (b == ALG_ELGAMAL) mpi_count = MPI_COUNT_ELGAMAL;
               else if (b == ALG_DSA) mpi_count = MPI_COUNT_DSA;
               else mpi_count = MPI_COUNT_NONE;
               if (mpi_count == MPI_COUNT_NONE) begin
                  raise_status(STATUS_BAD_ALGO);
                  phase = PH_TRAIL;
               end else begin
                  phase = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               tag.field_kind = KIND_LENGTH;
               tag.mpi_number = mpi_index;
               tag.offset_in_field = offset[12:0];
               if (offset == 14'd0) begin
                  length_high = b;
                  offset = 14'd1;
               end else begin
                  bits = {1'b0, length_high, b};
                  tag.field_done = 1'b1;
                  bytes_left = 14'((bits + 17'd7) >> 3);
                  offset = '0;
                  if (bytes_left != 14'd0) phase = PH_DATA;
                  else advance_integer();
               end
            end
            PH_DATA: begin
               tag.field_kind = KIND_DATA;
               tag.mpi_number = mpi_index;
               tag.offset_in_field = offset[12:0];
               if (bytes_left > 14'd0) bytes_left = bytes_left - 14'd1;
               if (bytes_left == 14'd0) begin
                  tag.field_done = 1'b1;
                  advance_integer();
               end else begin
                  offset = offset + 14'd1;
               end
            end
            default: begin
               tag.offset_in_field = (offset > TRAIL_OFFSET_MAX) ? TRAIL_OFFSET_MAX[12:0]
                                                                 : offset[12:0];
               if (offset < TRAIL_OFFSET_MAX) offset = offset + 14'd1;
            end
         endcase

         if (last && phase != PH_TRAIL) raise_status(STATUS_TRUNCATED);

         case (mpi_count)
            MPI_COUNT_RSA:     tag.algorithm_class = CLASS_RSA;
            MPI_COUNT_ELGAMAL: tag.algorithm_class = CLASS_ELGAMAL;
            MPI_COUNT_DSA:     tag.algorithm_class = CLASS_DSA;
            default:           tag.algorithm_class = CLASS_UNKNOWN;
         endcase
         tag.created_time = time_acc;
         tag.status = sticky;
         expected_tags.push_back(tag);
         if (last) clear_state();
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_tagged_byte(result_type got);
         result_type want;
         if (expected_tags.size() == 0) begin
            $error("result transfer with no byte outstanding");
            mismatches++;
            return;
         end
         want = expected_tags.pop_front();
         compare_field("field_kind", want.field_kind, got.field_kind);
         compare_field("mpi_number", want.mpi_number, got.mpi_number);
         compare_field("offset_in_field", want.offset_in_field, got.offset_in_field);
         compare_field("byte_value", want.byte_value, got.byte_value);
         compare_field("field_done", want.field_done, got.field_done);
         compare_field("algorithm_class", want.algorithm_class, got.algorithm_class);
         compare_field("created_time", want.created_time, got.created_time);
         compare_field("status", want.status, got.status);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   byte_tag_checker tag_check;

   pkpb_req_if req_chan();
   pkpb_rsp_if rsp_chan();

   pgp_public_key_body_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      result_type seen;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            tag_check.note_body_byte(req_chan.body_byte, req_chan.body_end);
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.field_kind      = rsp_chan.field_kind;
            seen.mpi_number      = rsp_chan.mpi_number;
            seen.offset_in_field = rsp_chan.offset_in_field;
            seen.byte_value      = rsp_chan.byte_value;
            seen.field_done      = rsp_chan.field_done;
            seen.algorithm_class = rsp_chan.algorithm_class;
            seen.created_time    = rsp_chan.created_time;
            seen.status          = rsp_chan.status;
            tag_check.check_tagged_byte(seen);
         end
      end
   end

   // result side backpressure in bursts
   initial begin
      int burst;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) < recv_idle_pct) begin
            burst = $urandom_range(1, 16);
            rsp_chan.ready = 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   task automatic send_body(input logic [7:0] body[$]);
      int gap;
      foreach (body[i]) begin
         if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 16);
            req_chan.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_chan.valid = 1'b1;
         req_chan.body_byte = body[i];
         req_chan.body_end = (i == body.size() - 1);
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         @(negedge clock);
      end
   endtask

   task automatic pick_idling();
      case ($urandom_range(0, 3))
         0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         1: begin send_idle_pct = 5;  recv_idle_pct = 10; end
         2: begin send_idle_pct = 20; recv_idle_pct = 20; end
         default: begin send_idle_pct = 50; recv_idle_pct = 40; end
      endcase
   endtask

   task automatic build_random_body(output logic [7:0] body[$]);
      int form, mpis, bits, cut;
      logic [7:0] algo;
      body = {};
      form = $urandom_range(0, 99);
      if (form < 10) begin
         // noise that usually fails at the version or algorithm byte
         repeat ($urandom_range(1, 12)) body.push_back(8'($urandom));
      end else begin
         body.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : VERSION_CODE);
         repeat (4) body.push_back(8'($urandom));
         case ($urandom_range(0, 11))
            0, 1:    algo = ALG_RSA_ENC_SIGN;
            2:       algo = ALG_RSA_ENC;
            3:       algo = ALG_RSA_SIGN;
            4, 5, 6: algo = ALG_ELGAMAL;
            7, 8, 9: algo = ALG_DSA;
            10:      algo = $urandom_range(0, 1) ? 8'($urandom_range(18, 255))
                                                 : 8'($urandom_range(4, 15));
            default: algo = 8'd0;
         endcase
         body.push_back(algo);
         if (algo >= ALG_RSA_ENC_SIGN && algo <= ALG_RSA_SIGN) mpis = 2;
         else if (algo == ALG_ELGAMAL) mpis = 3;
         else if (algo == ALG_DSA) mpis = 4;
         else mpis = 0;
         for (int m = 0; m < mpis; m++) begin
            case ($urandom_range(0, 9))
               0:       bits = 0;
               1:       bits = 8 * $urandom_range(1, 6);
               2:       bits = 8 * $urandom_range(0, 5) + 1;
               3:       bits = $urandom_range(256, 600);
               default: bits = $urandom_range(1, 48);
            endcase
            body.push_back(8'(bits >> 8));
            body.push_back(8'(bits));
            repeat ((bits + 7) / 8) body.push_back(8'($urandom));
         end
         repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
      end
      // some bodies end early
      if (body.size() > 1 && $urandom_range(0, 6) == 0) begin
         cut = $urandom_range(0, body.size() - 2);
         body = body[0:cut];
      end
   endtask

   initial begin
      logic [7:0] body[$];
      int sent;
      tag_check = new();
      req_chan.valid = 1'b0;
      req_chan.body_byte = 8'h00;
      req_chan.body_end = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      sent = 0;
      send_idle_pct = 20;
      recv_idle_pct = 20;
      // bad version on a one byte body
      body = {8'h00};
      send_body(body);
      sent += body.size();
      // bad version keeps parsing; zero length integers; eight bit integer
      body = {8'hFF, 8'h80, 8'h00, 8'h00, 8'h01, ALG_ELGAMAL,
              8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h5A};
      send_body(body);
      sent += body.size();
      // bad algorithm then trailing bytes, time all ones
      body = {VERSION_CODE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hAA};
      send_body(body);
      sent += body.size();
      // truncated inside the time field
      body = {VERSION_CODE, 8'h12};
      send_body(body);
      sent += body.size();

      // long integer with a rounded up length, then an empty one
      pick_idling();
      body = {VERSION_CODE, 8'h01, 8'h02, 8'h03, 8'h04, ALG_RSA_ENC_SIGN, 8'h04, 8'h01};
      repeat (129) body.push_back(8'($urandom));
      body.push_back(8'h00);
      body.push_back(8'h00);
      send_body(body);
      sent += body.size();
      // long run of trailing bytes after a bad algorithm
      pick_idling();
      body = {VERSION_CODE, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
      repeat (40) body.push_back(8'($urandom));
      send_body(body);
      sent += body.size();

      while (sent < 1350) begin
         if (sent > 1150) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            pick_idling();
         end
         build_random_body(body);
         send_body(body);
         sent += body.size();
      end
      req_chan.valid = 1'b0;

      while (tag_check.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tag_check.mismatches == 0 && tag_check.pending() == 0) begin
         $display("pgp_public_key_body_parser regression: pass");
      end else begin
         $display("pgp_public_key_body_parser regression: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("pgp_public_key_body_parser regression: fail");
      $finish;
   end

endmodule
